// File: design/fat_pkg.sv
package fat_pkg;

    // Command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_ALLOC = 2'd2;
    localparam logic [1:0] CMD_FREE  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    // Link values
    localparam logic [15:0] FIRST_DATA_CLUSTER = 16'h0002;
    localparam logic [15:0] RESERVED_LINK_MIN  = 16'hFFF0;
    localparam logic [15:0] END_OF_CHAIN       = 16'hFFFF;
    localparam logic [15:0] FREE_LINK          = 16'h0000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] cluster;
        logic [15:0] value;
    } t_fat_req;

    typedef struct packed {
        logic [15:0] data;
        logic [1:0]  status;
        logic [12:0] freed_count;
    } t_fat_rsp;

    typedef enum logic [1:0] {
        WR_VALUE,
        WR_FREE,
        WR_EOC
    } t_wr_sel;

    typedef enum logic {
        DATA_RDATA,
        DATA_CUR
    } t_data_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      clr_wr;
        logic      rd_en;
        logic      wr_en;
        t_wr_sel   wr_sel;
        logic      cur_inc;
        logic      cur_follow;
        logic      freed_inc;
        logic      data_cap;
        t_data_sel data_sel;
        logic      status_set;
        logic [1:0] status_code;
    } t_fat_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] cmd;
        logic       cur_in_table;
        logic       cur_in_chain;
        logic       rdata_free;
        logic       freed_full;
        logic       clr_last;
    } t_fat_sts;

endpackage

// File: design/fat_ram.sv
module fat_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/fat_dp.sv
module fat_dp
    import fat_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_fat_req i_req,
    input  t_fat_ctl i_ctl,
    output t_fat_sts o_sts,
    output t_fat_rsp o_rsp
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int FW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [16:0]   TABLE_LIMIT = 17'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(TABLE_ENTRIES - 1);
    localparam logic [FW-1:0] FREED_MAX   = FW'(TABLE_ENTRIES);

    logic [1:0]    r_cmd;
    logic [15:0]   r_cur;
    logic [15:0]   r_value;
    logic [15:0]   r_data;
    logic [1:0]    r_status;
    logic [FW-1:0] r_freed;
    logic [AW-1:0] r_clr_addr;

    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic [15:0]   rdata;

    // Write port select: clearing pass or command write
    assign we    = i_ctl.clr_wr | i_ctl.wr_en;
    assign waddr = i_ctl.clr_wr ? r_clr_addr : r_cur[AW-1:0];

    always_comb begin
        case (i_ctl.wr_sel)
            WR_VALUE: wdata = r_value;
            WR_EOC:   wdata = END_OF_CHAIN;
            default:  wdata = FREE_LINK;
        endcase
        if (i_ctl.clr_wr) begin
            wdata = FREE_LINK;
        end
    end

    fat_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (rdata)
    );

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctl.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Capture command, walk the cursor, collect the result
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_req.cmd;
            r_value  <= i_req.value;
            r_cur    <= (i_req.cmd == CMD_ALLOC) ? FIRST_DATA_CLUSTER : i_req.cluster;
            r_data   <= '0;
            r_status <= ST_OK;
            r_freed  <= '0;
        end else begin
            if (i_ctl.cur_inc) begin
                r_cur <= r_cur + 16'd1;
            end else if (i_ctl.cur_follow) begin
                r_cur <= rdata;
            end
            if (i_ctl.freed_inc) begin
                r_freed <= r_freed + FW'(1);
            end
            if (i_ctl.data_cap) begin
                r_data <= (i_ctl.data_sel == DATA_CUR) ? r_cur : rdata;
            end
            if (i_ctl.status_set) begin
                r_status <= i_ctl.status_code;
            end
        end
    end

    assign o_sts.cmd          = r_cmd;
    assign o_sts.cur_in_table = ({1'b0, r_cur} < TABLE_LIMIT);
    assign o_sts.cur_in_chain = (r_cur >= FIRST_DATA_CLUSTER) && (r_cur < RESERVED_LINK_MIN);
    assign o_sts.rdata_free   = (rdata == FREE_LINK);
    assign o_sts.freed_full   = (r_freed == FREED_MAX);
    assign o_sts.clr_last     = (r_clr_addr == LAST_ADDR);

    assign o_rsp.data        = r_data;
    assign o_rsp.status      = r_status;
    assign o_rsp.freed_count = 13'(r_freed);

endmodule

// File: design/fat_ctrl.sv
module fat_ctrl
    import fat_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_done,
    input  t_fat_sts i_sts,
    output t_fat_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_READ_DATA,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_FREE_RD,
        S_FREE_WR
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    // Sequence commands and pick the next state
    always_comb begin
        o_ctl       = '0;
        o_ctl.wr_sel   = WR_FREE;
        o_ctl.data_sel = DATA_RDATA;
        n_state     = r_state;
        n_done      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.cmd)
                    CMD_READ: begin
                        if (i_sts.cur_in_table) begin
                            o_ctl.rd_en = 1'b1;
                            n_state     = S_READ_DATA;
                        end else begin
                            o_ctl.status_set  = 1'b1;
                            o_ctl.status_code = ST_BAD;
                            n_done            = 1'b1;
                            n_state           = S_IDLE;
                        end
                    end
                    CMD_WRITE: begin
                        if (i_sts.cur_in_table) begin
                            o_ctl.wr_en  = 1'b1;
                            o_ctl.wr_sel = WR_VALUE;
                        end else begin
                            o_ctl.status_set  = 1'b1;
                            o_ctl.status_code = ST_BAD;
                        end
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    CMD_ALLOC: n_state = S_ALLOC_RD;
                    default:   n_state = S_FREE_RD;
                endcase
            end
            S_READ_DATA: begin
                o_ctl.data_cap = 1'b1;
                o_ctl.data_sel = DATA_RDATA;
                n_done         = 1'b1;
                n_state        = S_IDLE;
            end
            S_ALLOC_RD: begin
                if (i_sts.cur_in_table) begin
                    o_ctl.rd_en = 1'b1;
                    n_state     = S_ALLOC_CHK;
                end else begin
                    o_ctl.status_set  = 1'b1;
                    o_ctl.status_code = ST_NO_FREE;
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_ALLOC_CHK: begin
                if (i_sts.rdata_free) begin
                    // claim the entry as a one-cluster chain
                    o_ctl.wr_en    = 1'b1;
                    o_ctl.wr_sel   = WR_EOC;
                    o_ctl.data_cap = 1'b1;
                    o_ctl.data_sel = DATA_CUR;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_ctl.cur_inc = 1'b1;
                    n_state       = S_ALLOC_RD;
                end
            end
            S_FREE_RD: begin
                if (!i_sts.cur_in_chain) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (!i_sts.cur_in_table || i_sts.freed_full) begin
                    o_ctl.status_set  = 1'b1;
                    o_ctl.status_code = ST_BAD;
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    n_state     = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                // zero this link and step to the next cluster
                o_ctl.wr_en      = 1'b1;
                o_ctl.wr_sel     = WR_FREE;
                o_ctl.freed_inc  = 1'b1;
                o_ctl.cur_follow = 1'b1;
                n_state          = S_FREE_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// File: design/fat_cluster_chain_manager.sv
// FAT16 cluster chain manager: a table of 16-bit cluster links with read,
// write, allocate and free-chain commands.
// Command channel: a transfer takes place at a rising edge with start high
// and busy low; i_req carries cmd, cluster and value.
// Result channel: o_done is high for exactly one cycle while o_rsp holds
// data, status and freed_count; the receiver takes it at the end of that
// cycle and cannot hold it off. The strobe cycle already shows busy low, so
// the next command may be transferred in it.
// Sequence from transfer to strobe: a write completes in the dispatch state, a read
// adds one table read, allocate scans entries upward from cluster 2 and free chain
// walks the chain and zeroes its links. Every table visit is a read state and then
// a compare/write state, since the table read port is registered.
// Reset: a clearing pass writes zero to every entry, one per cycle; busy stays
// high until it finishes.
module fat_cluster_chain_manager
    import fat_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_fat_req i_req,
    output logic     o_done,
    output t_fat_rsp o_rsp
);

    t_fat_ctl ctl;
    t_fat_sts sts;

    fat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    fat_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

// File: dv/fat_chain_checker.sv
module fat_chain_checker
    import fat_pkg::*;
#(
    parameter int TABLE_SIZE = 4096
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_fat_req i_req,
    input  logic     i_done,
    input  t_fat_rsp i_rsp,
    output int       o_err_count,
    output int       o_outstanding
);

    // Shadow copy of the link table, updated in transfer order
    logic [15:0] link_mirror [TABLE_SIZE];
    t_fat_rsp    rsp_fifo [$];
    t_fat_rsp    want;
    int          mismatches = 0;
    int          pending = 0;

    assign o_err_count   = mismatches;
    assign o_outstanding = pending;

    // Apply one command to the shadow table and return the result it must give
    function automatic t_fat_rsp run_fat_cmd(input t_fat_req req);
        t_fat_rsp    rsp;
        int unsigned cur;
        int unsigned nxt;
        int unsigned visits;
        logic        stop;
        rsp    = '0;
        stop   = 1'b0;
        visits = 0;
        case (req.cmd)
            CMD_READ: begin
                if (req.cluster < TABLE_SIZE) rsp.data = link_mirror[req.cluster];
                else rsp.status = ST_BAD;
            end
            CMD_WRITE: begin
                if (req.cluster < TABLE_SIZE) link_mirror[req.cluster] = req.value;
                else rsp.status = ST_BAD;
            end
            CMD_ALLOC: begin
                // Take the lowest free data cluster and mark it end of chain
                rsp.status = ST_NO_FREE;
                for (cur = FIRST_DATA_CLUSTER;
                     cur < RESERVED_LINK_MIN && cur < TABLE_SIZE && !stop; cur++) begin
                    if (link_mirror[cur] == FREE_LINK) begin
                        link_mirror[cur] = END_OF_CHAIN;
                        rsp.data   = cur[15:0];
                        rsp.status = ST_OK;
                        stop       = 1'b1;
                    end
                end
            end
            default: begin
                // Walk the chain, zeroing and counting every visited entry
                cur = req.cluster;
                while (!stop && cur >= FIRST_DATA_CLUSTER && cur < RESERVED_LINK_MIN) begin
                    if (cur >= TABLE_SIZE || visits >= TABLE_SIZE) begin
                        rsp.status = ST_BAD;
                        stop       = 1'b1;
                    end else begin
                        nxt              = link_mirror[cur];
                        link_mirror[cur] = FREE_LINK;
                        visits++;
                        cur = nxt;
                    end
                end
                rsp.freed_count = visits[12:0];
            end
        endcase
        return rsp;
    endfunction

    // Check a result against the oldest prediction, then predict the new transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (link_mirror[k]) link_mirror[k] = FREE_LINK;
            rsp_fifo.delete();
            mismatches = 0;
        end else begin
            if (i_done) begin
                if (rsp_fifo.size() == 0) begin
                    $error("result with nothing pending: data %h status %0d freed_count %0d",
                           i_rsp.data, i_rsp.status, i_rsp.freed_count);
                    mismatches++;
                end else begin
                    want = rsp_fifo.pop_front();
                    if (i_rsp.data !== want.data) begin
                        $error("data: expected %h, got %h", want.data, i_rsp.data);
                        mismatches++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_rsp.status);
                        mismatches++;
                    end
                    if (i_rsp.freed_count !== want.freed_count) begin
                        $error("freed_count: expected %0d, got %0d",
                               want.freed_count, i_rsp.freed_count);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) rsp_fifo.push_back(run_fat_cmd(i_req));
        end
        pending = rsp_fifo.size();
    end

endmodule

// File: dv/tb.sv
module tb;
    import fat_pkg::*;

    localparam int TABLE_SIZE      = 4096;
    localparam int CYCLE_LIMIT     = 6_000_000;
    localparam int DRAIN_CYCLES    = 2 * TABLE_SIZE + 16;
    localparam int ITEMS_PER_PHASE = 36;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_fat_req req;
    logic     done;
    t_fat_rsp rsp;
    int       err_count;
    int       outstanding;
    int       cycles = 0;
    int       idle_pct;
    int       items_sent;
    int       mark;
    int       phase;
    int       pick;

    fat_cluster_chain_manager #(
        .TABLE_ENTRIES(TABLE_SIZE)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (req),
        .o_done (done),
        .o_rsp  (rsp)
    );

    fat_chain_checker #(
        .TABLE_SIZE(TABLE_SIZE)
    ) chain_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_done       (done),
        .i_rsp        (rsp),
        .o_err_count  (err_count),
        .o_outstanding(outstanding)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_fat_req fat_cmd(input logic [1:0] op, input logic [15:0] cl,
                                         input logic [15:0] val);
        t_fat_req r;
        r.cmd     = op;
        r.cluster = cl;
        r.value   = val;
        return r;
    endfunction

    // Idle at random, then hold the command until the block takes the transfer
    task automatic issue(input logic [1:0] op, input logic [15:0] cl, input logic [15:0] val);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            req   <= fat_cmd(2'($urandom), 16'($urandom), 16'($urandom));
            @(posedge i_clk);
        end
        start <= 1'b1;
        req   <= fat_cmd(op, cl, val);
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Build a chain by writes, end it in some terminator or a loop, then free it
    task automatic chain_free();
        int unsigned node [49];
        int unsigned hops;
        int unsigned base;
        int unsigned k;
        logic        scattered;
        logic [15:0] tail;
        hops      = ($urandom_range(9) == 0) ? $urandom_range(48, 9) : $urandom_range(6, 1);
        base      = $urandom_range(TABLE_SIZE - 49, 2);
        scattered = 1'($urandom);
        for (k = 0; k < hops; k++)
            node[k] = scattered ? $urandom_range(TABLE_SIZE - 1, 2) : base + k;
        node[hops] = 0;
        case ($urandom_range(5))
            0: tail = END_OF_CHAIN;
            1: tail = 16'($urandom_range(16'hFFFE, 16'hFFF0));
            2: tail = 16'($urandom_range(16'hFFEF, TABLE_SIZE));
            3: tail = 16'($urandom_range(1));
            default: tail = 16'(node[$urandom_range(hops - 1)]);
        endcase
        for (k = 0; k < hops; k++)
            issue(CMD_WRITE, 16'(node[k]), (k == hops - 1) ? tail : 16'(node[k + 1]));
        if ($urandom_range(3) == 0)
            issue(CMD_READ, 16'(node[$urandom_range(hops - 1)]), 16'($urandom));
        k = ($urandom_range(7) == 0) ? $urandom_range(hops - 1) : 0;
        issue(CMD_FREE, 16'(node[k]), 16'($urandom));
    endtask

    // Allocate a few clusters, then release some of the low region
    task automatic alloc_burst();
        int unsigned n;
        n = $urandom_range(4, 1);
        repeat (n) issue(CMD_ALLOC, 16'($urandom), 16'($urandom));
        repeat (n) issue(CMD_FREE, 16'($urandom_range(40, 2)), 16'($urandom));
    endtask

    // Single command with random fields
    task automatic stray_cmd();
        logic [15:0] cl;
        cl = $urandom_range(1) ? 16'($urandom_range(TABLE_SIZE - 1)) : 16'($urandom);
        issue(2'($urandom), cl, 16'($urandom));
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        req        <= '0;
        idle_pct   = 31;
        items_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Boundary indexes on a fresh table
        issue(CMD_READ, 16'd0, 16'hFFFF);
        issue(CMD_READ, 16'(TABLE_SIZE - 1), 16'h0000);
        issue(CMD_READ, 16'(TABLE_SIZE), 16'h0000);
        issue(CMD_READ, 16'hFFFF, 16'h0000);
        // Reserved entries 0 and 1 take writes like any other
        issue(CMD_WRITE, 16'd0, 16'hFFFF);
        issue(CMD_WRITE, 16'd1, 16'h1234);
        issue(CMD_READ, 16'd0, 16'h0000);
        issue(CMD_READ, 16'd1, 16'h0000);
        // Writes outside the table, then allocates with ignored fields
        issue(CMD_WRITE, 16'hFFFF, 16'hA5A5);
        issue(CMD_WRITE, 16'(TABLE_SIZE), 16'h0001);
        issue(CMD_ALLOC, 16'h0000, 16'h0000);
        issue(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
        // Start clusters that free nothing
        issue(CMD_FREE, 16'd0, 16'h0000);
        issue(CMD_FREE, 16'd1, 16'h0000);
        issue(CMD_FREE, RESERVED_LINK_MIN, 16'h0000);
        issue(CMD_FREE, 16'hFFFF, 16'h0000);
        // Loop: the revisited entry is counted again
        issue(CMD_WRITE, 16'd2, 16'd3);
        issue(CMD_WRITE, 16'd3, 16'd2);
        issue(CMD_FREE, 16'd2, 16'h0000);
        // Link just past the table
        issue(CMD_WRITE, 16'd5, 16'd6);
        issue(CMD_WRITE, 16'd6, 16'(TABLE_SIZE));
        issue(CMD_FREE, 16'd5, 16'h0000);
        // Reserved terminator on the top entry
        issue(CMD_WRITE, 16'(TABLE_SIZE - 1), RESERVED_LINK_MIN);
        issue(CMD_FREE, 16'(TABLE_SIZE - 1), 16'h0000);
        // Highest link value that is still followed
        issue(CMD_WRITE, 16'd7, 16'hFFEF);
        issue(CMD_FREE, 16'd7, 16'h0000);

        // Random traffic under three sender idle rates
        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 31 : (phase == 1) ? 64 : 0;
            mark = items_sent;
            while (items_sent - mark < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 60) chain_free();
                else if (pick < 75) alloc_burst();
                else stray_cmd();
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for strays
        do @(negedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
